FILE: rtl/esc_pkg.sv
// shared types and constants for the environmental sensor compensation core
package esc_pkg;

    typedef enum logic [1:0] {
        MODE_TEMP  = 2'd0,
        MODE_PRESS = 2'd1,
        MODE_HUM   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    typedef enum logic [1:0] {
        OP_ALU,
        OP_MUL,
        OP_DIV,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        REG_TEMP    = 3'd0,
        REG_PRESS_A = 3'd1,
        REG_PRESS_B = 3'd2,
        REG_PRESS_C = 3'd3,
        REG_HUM_A   = 3'd4,
        REG_HUM_B   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic start;
        logic div;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_rsp_t;

    localparam logic [63:0] K_PRESS_OFFSET = 64'd128000;
    localparam logic [63:0] K_PRESS_SCALE  = 64'd3125;
    localparam logic [63:0] K_PRESS_FULL   = 64'd1048576;
    localparam logic [63:0] K_HUM_OFFSET   = 64'd76800;
    localparam logic [31:0] K_HUM_MAX      = 32'd419430400;
    localparam logic [63:0] K_HUM_BIAS_Y   = 64'd2097152;
    localparam logic [63:0] K_HUM_ROUND_X  = 64'd16384;
    localparam logic [63:0] K_HUM_BIAS_H3  = 64'd32768;
    localparam logic [63:0] K_HUM_ROUND_Y  = 64'd8192;
    localparam logic [63:0] K_TEMP_ROUND   = 64'd128;

endpackage

FILE: rtl/esc_arith.sv
// bit-serial 64-bit multiplier (low half) and unsigned restoring divider
module esc_arith (
    input  logic                aclk,
    input  logic                aresetn,
    input  esc_pkg::arith_req_t req,
    input  logic [63:0]         opnd_a,
    input  logic [63:0]         opnd_b,
    output esc_pkg::arith_rsp_t rsp,
    output logic [63:0]         result
);

    logic [63:0] acc_reg, acc_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        div_reg, div_next;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        fits;

    always_comb begin
        trial = {acc_reg, opb_reg[63]};
        diff  = trial - {1'b0, opa_reg};
        fits  = trial >= {1'b0, opa_reg};

        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;

        if (req.start) begin
            acc_next  = '0;
            div_next  = req.div;
            opa_next  = req.div ? opnd_b : opnd_a;
            opb_next  = req.div ? opnd_a : opnd_b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (div_reg) begin
                acc_next = fits ? diff[63:0] : trial[63:0];
                opb_next = {opb_reg[62:0], fits};
            end else begin
                if (opb_reg[0]) begin
                    acc_next = acc_reg + opa_reg;
                end
                opa_next = {opa_reg[62:0], 1'b0};
                opb_next = {1'b0, opb_reg[63:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = div_reg ? opb_reg : acc_reg;

endmodule

FILE: rtl/env_sensor_compensation_core.sv
// top level: sequenced integer compensation for temperature, pressure, humidity
//
// Input channel s_*: one raw reading (s_mode, s_adc_value) per transaction.
// Result channel m_*: one transaction per input, m_compensated_value and
// m_divide_guard, in input order.
// Configuration channel cfg_*: cfg_index selects one of the six calibration
// registers, cfg_data holds the value; cfg_ready is always high. Write only
// while no reading is in flight.
// A small sequencer steps through each formula on a shared bit-serial unit,
// one bit each cycle; a multiply or divide step is issued, runs over all 64
// bits and is handed back; adds and shifts are written by the sequencer itself.
// Pressure takes 10 multiplies and one divide and ends early with the guard
// flag when its divisor is zero; an unused mode goes straight to its result
// step. The next reading can be accepted in the same cycle that m_valid rises.
// A finished result waits in the output register, so the next reading is
// accepted and computed while m_ready is low, and it stalls only at its own
// result step.
// Reset clears the calibration registers, the stored fine temperature and
// all handshake state.
module env_sensor_compensation_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [19:0]        s_adc_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_compensated_value,
    output logic               m_divide_guard,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic [47:0] temp_cal_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;
    logic [39:0] hum_a_reg;
    logic [23:0] hum_b_reg;
    logic [31:0] fine_reg, fine_next;

    esc_pkg::state_t state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [1:0]  mode_reg, mode_next;
    logic [19:0] adc_reg, adc_next;
    logic        neg_reg, neg_next;
    logic [63:0] r_reg [5];
    logic        m_valid_reg, m_valid_next;
    logic [31:0] out_val_reg, out_val_next;
    logic        out_guard_reg, out_guard_next;

    esc_pkg::op_t kind;
    logic [2:0]  dest;
    logic [63:0] alu_val;
    logic [63:0] mul_a, mul_b;
    logic [31:0] res_val;
    logic        res_guard;
    logic        wr_fine;
    logic        set_neg;
    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [63:0] wr_val;

    esc_pkg::arith_req_t req;
    esc_pkg::arith_rsp_t rsp;
    logic [63:0] arith_result;

    logic [63:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6;
    logic [63:0] adc64, fine64, tf;
    logic [63:0] res_wide;
    logic [31:0] hv;

    function automatic logic [63:0] asr32(input logic [63:0] x, input logic [4:0] s);
        logic signed [63:0] w;
        w = {{32{x[31]}}, x[31:0]};
        return w >>> s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    esc_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opnd_a  (mul_a),
        .opnd_b  (mul_b),
        .rsp     (rsp),
        .result  (arith_result)
    );

    assign t1 = {48'd0, temp_cal_reg[15:0]};
    assign t2 = {{48{temp_cal_reg[31]}}, temp_cal_reg[31:16]};
    assign t3 = {{48{temp_cal_reg[47]}}, temp_cal_reg[47:32]};
    assign p1 = {48'd0, press_a_reg[15:0]};
    assign p2 = {{48{press_a_reg[31]}}, press_a_reg[31:16]};
    assign p3 = {{48{press_a_reg[47]}}, press_a_reg[47:32]};
    assign p4 = {{48{press_a_reg[63]}}, press_a_reg[63:48]};
    assign p5 = {{48{press_b_reg[15]}}, press_b_reg[15:0]};
    assign p6 = {{48{press_b_reg[31]}}, press_b_reg[31:16]};
    assign p7 = {{48{press_b_reg[47]}}, press_b_reg[47:32]};
    assign p8 = {{48{press_b_reg[63]}}, press_b_reg[63:48]};
    assign p9 = {{48{press_c_reg[15]}}, press_c_reg};
    assign h1 = {56'd0, hum_a_reg[7:0]};
    assign h2 = {{48{hum_a_reg[23]}}, hum_a_reg[23:8]};
    assign h3 = {56'd0, hum_a_reg[31:24]};
    assign h6 = {{56{hum_a_reg[39]}}, hum_a_reg[39:32]};
    assign h4 = {{52{hum_b_reg[11]}}, hum_b_reg[11:0]};
    assign h5 = {{52{hum_b_reg[23]}}, hum_b_reg[23:12]};
    assign adc64  = {44'd0, adc_reg};
    assign fine64 = {{32{fine_reg[31]}}, fine_reg};

    // formula sequencer: one entry per step of each mode
    always_comb begin
        kind      = esc_pkg::OP_ALU;
        dest      = 3'd0;
        alu_val   = '0;
        mul_a     = '0;
        mul_b     = '0;
        res_val   = '0;
        res_guard = 1'b0;
        wr_fine   = 1'b0;
        set_neg   = 1'b0;
        tf        = '0;
        res_wide  = '0;
        hv        = '0;
        unique case (esc_pkg::mode_t'(mode_reg))
            esc_pkg::MODE_TEMP: begin
                case (step_reg)
                    5'd0: begin
                        dest = 3'd0; alu_val = (adc64 >> 3) - (t1 << 1);
                    end
                    5'd1: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd0; mul_a = r_reg[0]; mul_b = t2;
                    end
                    5'd2: begin
                        dest = 3'd1; alu_val = (adc64 >> 4) - t1;
                    end
                    5'd3: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1;
                        mul_a = r_reg[1]; mul_b = r_reg[1];
                    end
                    5'd4: begin
                        dest = 3'd1; alu_val = asr32(r_reg[1], 5'd12);
                    end
                    5'd5: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1; mul_a = r_reg[1]; mul_b = t3;
                    end
                    default: begin
                        kind     = esc_pkg::OP_DONE;
                        tf       = asr32(r_reg[0], 5'd11) + asr32(r_reg[1], 5'd14);
                        wr_fine  = 1'b1;
                        res_wide = asr32((tf << 2) + tf + esc_pkg::K_TEMP_ROUND, 5'd8);
                        res_val  = res_wide[31:0];
                    end
                endcase
            end
            esc_pkg::MODE_PRESS: begin
                case (step_reg)
                    5'd0: begin
                        dest = 3'd0; alu_val = fine64 - esc_pkg::K_PRESS_OFFSET;
                    end
                    5'd1: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1;
                        mul_a = r_reg[0]; mul_b = r_reg[0];
                    end
                    5'd2: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd2; mul_a = r_reg[1]; mul_b = p6;
                    end
                    5'd3: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd3; mul_a = r_reg[0]; mul_b = p5;
                    end
                    5'd4: begin
                        dest = 3'd2; alu_val = r_reg[2] + (r_reg[3] << 17) + (p4 << 35);
                    end
                    5'd5: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1; mul_a = r_reg[1]; mul_b = p3;
                    end
                    5'd6: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd3; mul_a = r_reg[0]; mul_b = p2;
                    end
                    5'd7: begin
                        dest = 3'd1;
                        alu_val = (64'd1 << 47) + asr64(r_reg[1], 6'd8) + (r_reg[3] << 12);
                    end
                    5'd8: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1; mul_a = r_reg[1]; mul_b = p1;
                    end
                    5'd9: begin
                        dest = 3'd1; alu_val = asr64(r_reg[1], 6'd33);
                    end
                    5'd10: begin
                        // zero divisor ends the item with the guard flag
                        if (r_reg[1] == 64'd0) begin
                            kind      = esc_pkg::OP_DONE;
                            res_guard = 1'b1;
                        end else begin
                            dest    = 3'd3;
                            alu_val = ((esc_pkg::K_PRESS_FULL - adc64) << 31) - r_reg[2];
                        end
                    end
                    5'd11: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd3;
                        mul_a = r_reg[3]; mul_b = esc_pkg::K_PRESS_SCALE;
                    end
                    5'd12: begin
                        dest = 3'd4; alu_val = abs64(r_reg[1]); set_neg = 1'b1;
                    end
                    5'd13: begin
                        dest = 3'd3; alu_val = abs64(r_reg[3]);
                    end
                    5'd14: begin
                        kind = esc_pkg::OP_DIV; dest = 3'd3;
                        mul_a = r_reg[3]; mul_b = r_reg[4];
                    end
                    5'd15: begin
                        dest = 3'd3; alu_val = neg_reg ? 64'd0 - r_reg[3] : r_reg[3];
                    end
                    5'd16: begin
                        dest = 3'd0; alu_val = asr64(r_reg[3], 6'd13);
                    end
                    5'd17: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd0;
                        mul_a = r_reg[0]; mul_b = r_reg[0];
                    end
                    5'd18: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd0; mul_a = r_reg[0]; mul_b = p9;
                    end
                    5'd19: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1; mul_a = r_reg[3]; mul_b = p8;
                    end
                    default: begin
                        kind     = esc_pkg::OP_DONE;
                        tf       = r_reg[3] + asr64(r_reg[0], 6'd25) + asr64(r_reg[1], 6'd19);
                        res_wide = asr64(tf, 6'd8) + (p7 << 4);
                        res_val  = res_wide[31:0];
                    end
                endcase
            end
            esc_pkg::MODE_HUM: begin
                case (step_reg)
                    5'd0: begin
                        dest = 3'd0; alu_val = fine64 - esc_pkg::K_HUM_OFFSET;
                    end
                    5'd1: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1; mul_a = r_reg[0]; mul_b = h5;
                    end
                    5'd2: begin
                        dest = 3'd1;
                        alu_val = asr32((adc64 << 14) - (h4 << 20) - r_reg[1]
                                        + esc_pkg::K_HUM_ROUND_X, 5'd15);
                    end
                    5'd3: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd2; mul_a = r_reg[0]; mul_b = h6;
                    end
                    5'd4: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd3; mul_a = r_reg[0]; mul_b = h3;
                    end
                    5'd5: begin
                        dest = 3'd2; alu_val = asr32(r_reg[2], 5'd10);
                    end
                    5'd6: begin
                        dest = 3'd3; alu_val = asr32(r_reg[3], 5'd11) + esc_pkg::K_HUM_BIAS_H3;
                    end
                    5'd7: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd2;
                        mul_a = r_reg[2]; mul_b = r_reg[3];
                    end
                    5'd8: begin
                        dest = 3'd2; alu_val = asr32(r_reg[2], 5'd10) + esc_pkg::K_HUM_BIAS_Y;
                    end
                    5'd9: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd2; mul_a = r_reg[2]; mul_b = h2;
                    end
                    5'd10: begin
                        dest = 3'd2; alu_val = asr32(r_reg[2] + esc_pkg::K_HUM_ROUND_Y, 5'd14);
                    end
                    5'd11: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd1;
                        mul_a = r_reg[1]; mul_b = r_reg[2];
                    end
                    5'd12: begin
                        dest = 3'd2; alu_val = asr32(r_reg[1], 5'd15);
                    end
                    5'd13: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd2;
                        mul_a = r_reg[2]; mul_b = r_reg[2];
                    end
                    5'd14: begin
                        dest = 3'd2; alu_val = asr32(r_reg[2], 5'd7);
                    end
                    5'd15: begin
                        kind = esc_pkg::OP_MUL; dest = 3'd2; mul_a = r_reg[2]; mul_b = h1;
                    end
                    default: begin
                        kind     = esc_pkg::OP_DONE;
                        res_wide = asr32(r_reg[2], 5'd4);
                        hv       = r_reg[1][31:0] - res_wide[31:0];
                        if (hv[31]) begin
                            hv = '0;
                        end else if (hv > esc_pkg::K_HUM_MAX) begin
                            hv = esc_pkg::K_HUM_MAX;
                        end
                        res_val = {12'd0, hv[31:12]};
                    end
                endcase
            end
            default: begin
                kind = esc_pkg::OP_DONE;
            end
        endcase
    end

    // control
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        mode_next      = mode_reg;
        adc_next       = adc_reg;
        neg_next       = neg_reg;
        fine_next      = fine_reg;
        m_valid_next   = m_valid_reg;
        out_val_next   = out_val_reg;
        out_guard_next = out_guard_reg;
        req.start      = 1'b0;
        req.div        = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = dest;
        wr_val         = alu_val;
        s_ready        = (state_reg == esc_pkg::ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            esc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    adc_next   = s_adc_value;
                    step_next  = '0;
                    state_next = esc_pkg::ST_RUN;
                end
            end
            esc_pkg::ST_RUN: begin
                unique case (kind)
                    esc_pkg::OP_ALU: begin
                        wr_en     = 1'b1;
                        step_next = step_reg + 5'd1;
                        if (set_neg) begin
                            neg_next = r_reg[1][63] ^ r_reg[3][63];
                        end
                    end
                    esc_pkg::OP_MUL, esc_pkg::OP_DIV: begin
                        req.start  = 1'b1;
                        req.div    = (kind == esc_pkg::OP_DIV);
                        state_next = esc_pkg::ST_WAIT;
                    end
                    esc_pkg::OP_DONE: begin
                        // hold until the output register is free
                        if (!m_valid_reg || m_ready) begin
                            m_valid_next   = 1'b1;
                            out_val_next   = res_val;
                            out_guard_next = res_guard;
                            if (wr_fine) begin
                                fine_next = tf[31:0];
                            end
                            state_next = esc_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = esc_pkg::ST_IDLE;
                    end
                endcase
            end
            esc_pkg::ST_WAIT: begin
                if (rsp.done) begin
                    wr_en      = 1'b1;
                    wr_val     = arith_result;
                    step_next  = step_reg + 5'd1;
                    state_next = esc_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = esc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= esc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            fine_reg    <= '0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            fine_reg    <= fine_next;
            step_reg    <= step_next;
        end
        mode_reg      <= mode_next;
        adc_reg       <= adc_next;
        neg_reg       <= neg_next;
        out_val_reg   <= out_val_next;
        out_guard_reg <= out_guard_next;
        if (wr_en) begin
            r_reg[wr_idx] <= wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            press_c_reg  <= '0;
            hum_a_reg    <= '0;
            hum_b_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                esc_pkg::REG_TEMP:    temp_cal_reg <= cfg_data[47:0];
                esc_pkg::REG_PRESS_A: press_a_reg  <= cfg_data;
                esc_pkg::REG_PRESS_B: press_b_reg  <= cfg_data;
                esc_pkg::REG_PRESS_C: press_c_reg  <= cfg_data[15:0];
                esc_pkg::REG_HUM_A:   hum_a_reg    <= cfg_data[39:0];
                esc_pkg::REG_HUM_B:   hum_b_reg    <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready           = 1'b1;
    assign m_valid             = m_valid_reg;
    assign m_compensated_value = $signed(out_val_reg);
    assign m_divide_guard      = out_guard_reg;

endmodule

FILE: test/testbench.sv
// self-checking testbench for the sensor compensation core
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 800;

    typedef struct {
        bit [31:0] value;
        bit        guard;
    } reading_t;

    class compensation_board;
        bit [63:0]  cal [6];
        bit [31:0]  fine_temp;
        reading_t   pending_q [$];
        int         mismatches;
        int         results;
        int         guards;
        int         per_mode [4];

        function bit [31:0] sra32(bit [31:0] v, int unsigned s);
            return $unsigned($signed(v) >>> s);
        endfunction

        function bit [63:0] sra64(bit [63:0] v, int unsigned s);
            return $unsigned($signed(v) >>> s);
        endfunction

        function bit [63:0] sx16(bit [15:0] v);
            return {{48{v[15]}}, v};
        endfunction

        // signed divide, truncating toward zero
        function bit [63:0] sdiv(bit [63:0] a, bit [63:0] b);
            bit [63:0] ua;
            bit [63:0] ub;
            bit [63:0] q;
            ua = a[63] ? 64'd0 - a : a;
            ub = b[63] ? 64'd0 - b : b;
            q = ua / ub;
            return (a[63] ^ b[63]) ? 64'd0 - q : q;
        endfunction

        function void write_reg(esc_pkg::cfg_reg_t idx, bit [63:0] data);
            case (idx)
                esc_pkg::REG_TEMP:    cal[esc_pkg::REG_TEMP] = data & 64'hFFFF_FFFF_FFFF;
                esc_pkg::REG_PRESS_A: cal[esc_pkg::REG_PRESS_A] = data;
                esc_pkg::REG_PRESS_B: cal[esc_pkg::REG_PRESS_B] = data;
                esc_pkg::REG_PRESS_C: cal[esc_pkg::REG_PRESS_C] = data & 64'hFFFF;
                esc_pkg::REG_HUM_A:   cal[esc_pkg::REG_HUM_A] = data & 64'hFF_FFFF_FFFF;
                esc_pkg::REG_HUM_B:   cal[esc_pkg::REG_HUM_B] = data & 64'hFF_FFFF;
                default: ;
            endcase
        endfunction

        function bit [31:0] temperature(bit [19:0] adc);
            bit [31:0] a32, t1, t2, t3, w, d, tf;
            a32 = {12'b0, adc};
            t1 = {16'b0, cal[esc_pkg::REG_TEMP][15:0]};
            t2 = {{16{cal[esc_pkg::REG_TEMP][31]}}, cal[esc_pkg::REG_TEMP][31:16]};
            t3 = {{16{cal[esc_pkg::REG_TEMP][47]}}, cal[esc_pkg::REG_TEMP][47:32]};
            w = (a32 >> 3) - (t1 << 1);
            w = w * t2;
            w = sra32(w, 11);
            d = (a32 >> 4) - t1;
            d = d * d;
            d = sra32(d, 12);
            d = d * t3;
            d = sra32(d, 14);
            tf = w + d;
            fine_temp = tf;
            tf = tf * 32'd5 + 32'd128;
            return sra32(tf, 8);
        endfunction

        function bit [31:0] pressure(bit [19:0] adc, output bit guard);
            bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            bit [63:0] a, v1, v2, p, e1, e2;
            p1 = {48'b0, cal[esc_pkg::REG_PRESS_A][15:0]};
            p2 = sx16(cal[esc_pkg::REG_PRESS_A][31:16]);
            p3 = sx16(cal[esc_pkg::REG_PRESS_A][47:32]);
            p4 = sx16(cal[esc_pkg::REG_PRESS_A][63:48]);
            p5 = sx16(cal[esc_pkg::REG_PRESS_B][15:0]);
            p6 = sx16(cal[esc_pkg::REG_PRESS_B][31:16]);
            p7 = sx16(cal[esc_pkg::REG_PRESS_B][47:32]);
            p8 = sx16(cal[esc_pkg::REG_PRESS_B][63:48]);
            p9 = sx16(cal[esc_pkg::REG_PRESS_C][15:0]);
            a = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
            v2 = a * a * p6 + ((a * p5) << 17) + (p4 << 35);
            v1 = sra64(a * a * p3, 8) + ((a * p2) << 12);
            v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
            guard = (v1 == 64'd0);
            if (guard) return 32'd0;
            p = 64'd1048576 - {44'b0, adc};
            p = sdiv(((p << 31) - v2) * 64'd3125, v1);
            e1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
            e2 = sra64(p8 * p, 19);
            p = sra64(p + e1 + e2, 8) + (p7 << 4);
            return p[31:0];
        endfunction

        function bit [31:0] humidity(bit [19:0] adc);
            bit [31:0] h1, h2, h3, h4, h5, h6, v, x, y, s;
            h1 = {24'b0, cal[esc_pkg::REG_HUM_A][7:0]};
            h2 = {{16{cal[esc_pkg::REG_HUM_A][23]}}, cal[esc_pkg::REG_HUM_A][23:8]};
            h3 = {24'b0, cal[esc_pkg::REG_HUM_A][31:24]};
            h6 = {{24{cal[esc_pkg::REG_HUM_A][39]}}, cal[esc_pkg::REG_HUM_A][39:32]};
            h4 = {{20{cal[esc_pkg::REG_HUM_B][11]}}, cal[esc_pkg::REG_HUM_B][11:0]};
            h5 = {{20{cal[esc_pkg::REG_HUM_B][23]}}, cal[esc_pkg::REG_HUM_B][23:12]};
            v = fine_temp - 32'd76800;
            x = sra32(({12'b0, adc} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
            y = sra32(sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768), 10);
            y = sra32((y + 32'd2097152) * h2 + 32'd8192, 14);
            v = x * y;
            s = sra32(v, 15);
            v = v - sra32(sra32(s * s, 7) * h1, 4);
            if (v[31]) v = 32'd0;
            if (v > 32'd419430400) v = 32'd419430400;
            return v >> 12;
        endfunction

        function void note_reading(bit [1:0] m, bit [19:0] adc);
            reading_t r;
            r.value = 32'd0;
            r.guard = 1'b0;
            case (esc_pkg::mode_t'(m))
                esc_pkg::MODE_TEMP:  r.value = temperature(adc);
                esc_pkg::MODE_PRESS: r.value = pressure(adc, r.guard);
                esc_pkg::MODE_HUM:   r.value = humidity(adc);
                default: ;
            endcase
            per_mode[m]++;
            pending_q.push_back(r);
        endfunction

        function void check_reading(bit [31:0] value, bit guard);
            reading_t r;
            results++;
            if (guard) guards++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h guard %b", value, guard);
                return;
            end
            r = pending_q.pop_front();
            if (r.value !== value || r.guard !== guard) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %h guard %b, got value %h guard %b",
                             r.value, r.guard, value, guard);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [19:0] s_adc_value;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_compensated_value;
    logic        m_divide_guard;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    compensation_board board;
    int src_idle;
    int snk_idle;
    int hold_left;
    int quiet_cycles;

    env_sensor_compensation_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_adc_value(s_adc_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_compensated_value(m_compensated_value), .m_divide_guard(m_divide_guard),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver side, including the long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // transaction monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_reading(s_mode, s_adc_value);
            if (m_valid && m_ready) board.check_reading(m_compensated_value, m_divide_guard);
            if (cfg_valid && cfg_ready)
                board.write_reg(esc_pkg::cfg_reg_t'(cfg_index), cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic bit [63:0] typical_cal(esc_pkg::cfg_reg_t idx);
        case (idx)
            esc_pkg::REG_TEMP:    return {16'hFC18, 16'd26435, 16'd27504};
            esc_pkg::REG_PRESS_A: return {16'd2855, 16'd3024, 16'hD643, 16'd36477};
            esc_pkg::REG_PRESS_B: return {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
            esc_pkg::REG_PRESS_C: return 64'd6000;
            esc_pkg::REG_HUM_A:   return {8'd30, 8'd0, 16'd362, 8'd75};
            esc_pkg::REG_HUM_B:   return {12'd0, 12'd324};
            default:              return 64'd0;
        endcase
    endfunction

    task automatic write_cal(esc_pkg::cfg_reg_t idx, bit [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_reading(bit [1:0] m, bit [19:0] adc);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= m;
        s_adc_value <= adc;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        // let the monitor note the last accepted transaction first
        @(posedge aclk);
        while (board.pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_reading();
        bit [1:0]  m;
        bit [19:0] adc;
        int r;
        r = $urandom_range(99);
        m = (r < 35) ? esc_pkg::MODE_TEMP : (r < 65) ? esc_pkg::MODE_PRESS :
            (r < 95) ? esc_pkg::MODE_HUM : esc_pkg::MODE_NONE;
        case ($urandom_range(3))
            0: adc = ($urandom_range(1) == 0) ? 20'h00000 : 20'hFFFFF;
            1: begin
                if (m == esc_pkg::MODE_TEMP) adc = 20'($urandom_range(540000, 500000));
                else if (m == esc_pkg::MODE_PRESS) adc = 20'($urandom_range(450000, 300000));
                else adc = 20'($urandom_range(40000, 20000));
            end
            default: adc = 20'($urandom());
        endcase
        send_reading(m, adc);
    endtask

    initial begin
        bit [63:0] data;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = esc_pkg::MODE_TEMP;
        s_adc_value = '0;
        cfg_valid = 1'b0;
        cfg_index = esc_pkg::REG_TEMP;
        cfg_data = '0;
        src_idle = 0;
        snk_idle = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 6; ph++) begin
            src_idle = (ph < 2) ? 12 : (ph < 4) ? 87 : 0;
            snk_idle = (ph < 2) ? 87 : (ph < 4) ? 12 : 0;
            for (int i = 0; i < 6; i++) begin
                case (ph)
                    1: data = '1;
                    2: data = '0;
                    3: data = {$urandom(), $urandom()};
                    4: data = typical_cal(esc_pkg::cfg_reg_t'(i))
                              ^ {$urandom_range(255), $urandom_range(7)};
                    default: data = typical_cal(esc_pkg::cfg_reg_t'(i));
                endcase
                write_cal(esc_pkg::cfg_reg_t'(i), data);
            end
            if (ph == 0) begin
                // pressure and humidity before any temperature reading
                send_reading(esc_pkg::MODE_PRESS, 20'd415148);
                send_reading(esc_pkg::MODE_HUM, 20'd30000);
                send_reading(esc_pkg::MODE_TEMP, 20'd519888);
                send_reading(esc_pkg::MODE_PRESS, 20'd415148);
                send_reading(esc_pkg::MODE_PRESS, 20'h00000);
                send_reading(esc_pkg::MODE_PRESS, 20'hFFFFF);
                send_reading(esc_pkg::MODE_HUM, 20'd30000);
                send_reading(esc_pkg::MODE_HUM, 20'h00000);
                send_reading(esc_pkg::MODE_HUM, 20'hFFFFF);
                send_reading(esc_pkg::MODE_NONE, 20'hFFFFF);
                send_reading(esc_pkg::MODE_HUM, 20'h0FFFF);
                send_reading(esc_pkg::MODE_TEMP, 20'h00000);
                send_reading(esc_pkg::MODE_PRESS, 20'd300000);
                send_reading(esc_pkg::MODE_TEMP, 20'hFFFFF);
                send_reading(esc_pkg::MODE_HUM, 20'd40000);
                send_reading(esc_pkg::MODE_NONE, 20'h00000);
            end
            if (ph == 5) hold_left = HOLD_CYCLES;
            repeat (ph == 0 ? 260 : 275) random_reading();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d temperature, %0d pressure, %0d humidity, %0d unused-mode readings",
                 board.per_mode[esc_pkg::MODE_TEMP], board.per_mode[esc_pkg::MODE_PRESS],
                 board.per_mode[esc_pkg::MODE_HUM], board.per_mode[esc_pkg::MODE_NONE]);
        $display("%0d results checked over six calibration sets, %0d zero-divisor guards",
                 board.results, board.guards);
        $display("%0d mismatches", board.mismatches);
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
